/* hw/rtl/bihrv_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bihrv_pkg
// shared constants, types and controller/datapath command and status structs
// ---------------------------------------------------------------------------
package bihrv_pkg;

  localparam int RATE_AVG_DEPTH_DEF      = 4;
  localparam int INTERVAL_DEPTH_DEF      = 30;
  localparam int AMPLITUDE_AVG_DEPTH_DEF = 4;

  localparam logic [11:0] SHORT_RESET = 12'd300;
  localparam logic [11:0] LONG_RESET  = 12'd1500;

  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_LONG  = 1'b1;

  // rate numerator 60000 * 256
  localparam logic [23:0] RATE_NUM = 24'd15360000;

  typedef struct packed {
    logic load;       // latch transaction, compute interval
    logic div_start;  // start rate divide
    logic push;       // write rings
    logic evict_rd;   // fetch oldest pair for eviction
    logic evict_sub;  // subtract evicted square
    logic add_sq;     // add newest square
    logic sum_step;   // accumulate one ring element
    logic sum_clr;
    logic fin_start;  // start mean divides and root
    logic out_load;
  } bihrv_cmd_t;

  typedef struct packed {
    logic accept;     // interval within bounds
    logic div_done;
    logic sum_done;
    logic fin_done;
  } bihrv_sts_t;

endpackage

/* hw/rtl/bihrv_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bihrv_datapath
// rings, running sums, serial divider and serial square root
// ---------------------------------------------------------------------------
module bihrv_datapath #(
  parameter int RATE_AVG_DEPTH      = 4,
  parameter int INTERVAL_DEPTH      = 30,
  parameter int AMPLITUDE_AVG_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic [31:0]         in_time,
  input  logic signed [15:0]  in_amp,
  input  bihrv_pkg::bihrv_cmd_t cmd,
  output bihrv_pkg::bihrv_sts_t sts,
  output logic [7:0]          mean_rate_bpm,
  output logic [11:0]         rmssd_ms,
  output logic signed [15:0]  mean_amplitude,
  output logic                beat_accepted
);
  import bihrv_pkg::*;

  localparam int RW = $clog2(RATE_AVG_DEPTH + 1);
  localparam int AW = $clog2(AMPLITUDE_AVG_DEPTH + 1);
  localparam int IW = $clog2(INTERVAL_DEPTH + 1);
  localparam int RS = (RATE_AVG_DEPTH > 1) ? $clog2(RATE_AVG_DEPTH) : 1;
  localparam int AS = (AMPLITUDE_AVG_DEPTH > 1) ? $clog2(AMPLITUDE_AVG_DEPTH) : 1;
  localparam int IS = $clog2(INTERVAL_DEPTH);
  localparam int SW = 24 + $clog2(INTERVAL_DEPTH);   // square sum width
  localparam int SCW = (RATE_AVG_DEPTH > AMPLITUDE_AVG_DEPTH) ? RW : AW;
  localparam int MAXD = (RATE_AVG_DEPTH > AMPLITUDE_AVG_DEPTH) ? RATE_AVG_DEPTH
                                                              : AMPLITUDE_AVG_DEPTH;
  localparam int RSUM = 16 + RW;
  localparam int ASUM = 16 + AW;

  logic [11:0] short_iv, long_iv;
  logic [31:0] prev_time;
  logic        prev_valid;
  logic [11:0] iv;
  logic signed [15:0] amp_l;
  logic        acc;

  logic [15:0] rate_ring [RATE_AVG_DEPTH];
  logic [15:0] amp_ring  [AMPLITUDE_AVG_DEPTH];
  logic [11:0] iv_mem    [INTERVAL_DEPTH];
  logic [RW-1:0] r_fill;
  logic [RS-1:0] r_slot;
  logic [AW-1:0] a_fill;
  logic [AS-1:0] a_slot;
  logic [IW-1:0] i_fill;
  logic [IS-1:0] i_slot;
  logic [SW-1:0] sq_sum;
  logic [11:0] last_iv;       // newest stored interval
  logic [11:0] rd_a, rd_b;    // registered memory reads

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      short_iv <= SHORT_RESET;
      long_iv  <= LONG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SHORT) short_iv <= cfg_data;
      else                        long_iv  <= cfg_data;
    end
  end

  // rate divider: 24 bit numerator, 12 bit divisor, one bit a cycle
  logic [23:0] dq;
  logic [12:0] drem;
  logic [4:0]  dcnt;
  logic        dbusy;
  logic [12:0] dtrial;
  assign dtrial = {drem[11:0], dq[23]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dq    <= RATE_NUM + 24'(iv[11:1]);
      drem  <= '0;
      dcnt  <= 5'd24;
      dbusy <= 1'b1;
    end else if (dbusy) begin
      if (dtrial >= {1'b0, iv[11:0]}) begin
        drem <= dtrial - {1'b0, iv[11:0]};
        dq   <= {dq[22:0], 1'b1};
      end else begin
        drem <= dtrial;
        dq   <= {dq[22:0], 1'b0};
      end
      dcnt <= dcnt - 5'd1;
      if (dcnt == 5'd1) dbusy <= 1'b0;
    end
  end
  assign sts.div_done = dbusy && (dcnt == 5'd1);
  logic [15:0] rate_sat;
  assign rate_sat = (dq[23:16] != 8'd0) ? 16'hFFFF : dq[15:0];

  function automatic logic [23:0] sqd(input logic [11:0] a, input logic [11:0] b);
    logic [11:0] d;
    d = (a > b) ? a - b : b - a;
    return 24'(d) * 24'(d);
  endfunction

  logic [IS-1:0] nx_slot;
  assign nx_slot = (i_slot == IS'(INTERVAL_DEPTH - 1)) ? '0 : i_slot + 1'b1;

  logic [SCW-1:0] scnt;
  logic [RSUM-1:0] rsum;
  logic signed [ASUM-1:0] asum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      prev_time  <= '0;
      r_fill <= '0; r_slot <= '0;
      a_fill <= '0; a_slot <= '0;
      i_fill <= '0; i_slot <= '0;
      sq_sum <= '0;
      acc    <= 1'b0;
    end else begin
      if (cmd.load) begin
        iv         <= 12'(in_time - prev_time);
        acc        <= prev_valid && ((in_time - prev_time) > 32'(short_iv))
                      && ((in_time - prev_time) < 32'(long_iv))
                      && (in_time != prev_time);
        amp_l      <= in_amp;
        prev_time  <= in_time;
        prev_valid <= 1'b1;
      end
      if (cmd.evict_rd) begin
        rd_a <= iv_mem[nx_slot];
        rd_b <= iv_mem[i_slot];
      end
      if (cmd.evict_sub && i_fill >= IW'(INTERVAL_DEPTH))
        sq_sum <= sq_sum - SW'(sqd(rd_a, rd_b));
      if (cmd.add_sq && i_fill != '0)
        sq_sum <= sq_sum + SW'(sqd(iv[11:0], last_iv));
      if (cmd.push) begin
        rate_ring[r_slot] <= rate_sat;
        r_slot <= (r_slot == RS'(RATE_AVG_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        if (r_fill < RW'(RATE_AVG_DEPTH)) r_fill <= r_fill + 1'b1;
        amp_ring[a_slot] <= amp_l;
        a_slot <= (a_slot == AS'(AMPLITUDE_AVG_DEPTH - 1)) ? '0 : a_slot + 1'b1;
        if (a_fill < AW'(AMPLITUDE_AVG_DEPTH)) a_fill <= a_fill + 1'b1;
        i_slot <= nx_slot;
        if (i_fill < IW'(INTERVAL_DEPTH)) i_fill <= i_fill + 1'b1;
      end
    end
  end

  // interval memory, write port only at push
  always_ff @(posedge clk) begin
    if (cmd.push) iv_mem[i_slot] <= iv[11:0];
  end
  always_ff @(posedge clk) begin
    if (cmd.push) last_iv <= iv[11:0];
  end

  // sums over the short rings, one element a cycle
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      scnt <= '0;
      rsum <= '0;
      asum <= '0;
    end else if (cmd.sum_step) begin
      if (scnt < SCW'(r_fill) && scnt < SCW'(RATE_AVG_DEPTH))
        rsum <= rsum + RSUM'(rate_ring[RS'(scnt)]);
      if (scnt < SCW'(a_fill) && scnt < SCW'(AMPLITUDE_AVG_DEPTH))
        asum <= asum + ASUM'($signed(amp_ring[AS'(scnt)]));
      scnt <= scnt + 1'b1;
    end
  end
  assign sts.sum_done = cmd.sum_step && (scnt == SCW'(MAXD - 1));

  // final: mean rate divide, mean amplitude divide, root search
  localparam int RNW = RSUM + 1;
  logic [RNW-1:0] mq;  logic [RNW-1:0] mr;  logic [RNW-1:0] md;
  logic [ASUM-1:0] aq; logic [ASUM-1:0] ar; logic [ASUM-1:0] ad;
  logic aneg;
  logic [5:0] fcnt;
  logic fbusy;
  logic [11:0] root;
  logic [3:0]  rbit;
  logic [SW+1:0] four_s;
  logic [IW-1:0] nd;
  // root trial is pipelined: square then scale by count
  logic [12:0] t2;
  logic [11:0] cand;
  logic [1:0]  rph;
  logic [25:0] tt;
  logic [SW+1:0] tprod;
  assign cand = root | (12'd1 << rbit);
  logic [RNW-1:0] mtr; logic [ASUM-1:0] atr;
  assign mtr = {mr[RNW-2:0], mq[RNW-1]};
  assign atr = {ar[ASUM-2:0], aq[ASUM-1]};
  logic [ASUM-1:0] amag;
  assign amag = asum[ASUM-1] ? ASUM'(-asum) : ASUM'(asum);

  always_ff @(posedge clk) begin
    if (rst) begin
      fbusy <= 1'b0;
    end else if (cmd.fin_start) begin
      mq    <= RNW'(rsum) + (RNW'(r_fill) << 7);
      md    <= RNW'(r_fill) << 8;
      mr    <= '0;
      aneg  <= asum[ASUM-1];
      aq    <= amag + ASUM'(a_fill >> 1);
      ad    <= ASUM'(a_fill);
      ar    <= '0;
      fcnt  <= 6'd0;
      fbusy <= 1'b1;
      root  <= '0;
      rbit  <= 4'd11;
      rph   <= 2'd0;
      four_s <= (SW+2)'(sq_sum) << 2;
      nd    <= i_fill - 1'b1;
    end else if (fbusy) begin
      if (fcnt < 6'(RNW)) begin
        if (mtr >= md) begin mr <= mtr - md; mq <= {mq[RNW-2:0], 1'b1}; end
        else begin mr <= mtr; mq <= {mq[RNW-2:0], 1'b0}; end
      end
      if (fcnt < 6'(ASUM)) begin
        if (atr >= ad) begin ar <= atr - ad; aq <= {aq[ASUM-2:0], 1'b1}; end
        else begin ar <= atr; aq <= {aq[ASUM-2:0], 1'b0}; end
      end
      fcnt <= fcnt + 6'd1;
      // root: four phases a bit
      unique case (rph)
        2'd0: begin t2 <= {cand, 1'b0} - 13'd1; rph <= 2'd1; end
        2'd1: begin tt <= 26'(t2) * 26'(t2); rph <= 2'd2; end
        2'd2: begin tprod <= (SW+2)'(tt) * (SW+2)'(nd); rph <= 2'd3; end
        default: begin
          if (tprod <= four_s) root <= cand;
          rph <= 2'd0;
          if (rbit == 4'd0) fbusy <= 1'b0;
          else rbit <= rbit - 4'd1;
        end
      endcase
    end
  end
  assign sts.fin_done = fbusy && (rph == 2'd3) && (rbit == 4'd0);
  assign sts.accept = acc;

  // outputs; the final root compare is folded in here
  logic [11:0] root_f;
  assign root_f = (tprod <= four_s) ? cand : root;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_rate_bpm  <= (r_fill == '0) ? 8'd0 :
                        (mq[RNW-1:8] != '0) ? 8'd255 : mq[7:0];
      mean_amplitude <= (a_fill == '0) ? 16'sd0 :
                        (aneg ? -$signed(aq[15:0]) : $signed(aq[15:0]));
      rmssd_ms       <= (i_fill < IW'(2)) ? 12'd0 : root_f;
      beat_accepted  <= acc;
    end
  end
endmodule

/* hw/rtl/bihrv_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bihrv_ctrl
// sequencer for one beat transaction and the output handshake
// ---------------------------------------------------------------------------
module bihrv_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output bihrv_pkg::bihrv_cmd_t cmd,
  input  bihrv_pkg::bihrv_sts_t sts
);
  import bihrv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV, S_RD, S_SUB, S_ADD, S_PUSH, S_CLR, S_SUM,
    S_FIN, S_WAIT, S_OUT
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = in_fire;
      S_CHECK: cmd.div_start = sts.accept;
      S_RD:    cmd.evict_rd = 1'b1;
      S_SUB:   cmd.evict_sub = 1'b1;
      S_ADD:   cmd.add_sq = 1'b1;
      S_PUSH:  cmd.push = 1'b1;
      S_CLR:   cmd.sum_clr = 1'b1;
      S_SUM:   cmd.sum_step = 1'b1;
      S_FIN:   cmd.fin_start = 1'b1;
      S_WAIT:  cmd.out_load = sts.fin_done;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_fire) state <= S_CHECK;
        S_CHECK: state <= sts.accept ? S_DIV : S_CLR;
        S_DIV:   if (sts.div_done) state <= S_RD;
        S_RD:    state <= S_SUB;
        S_SUB:   state <= S_ADD;
        S_ADD:   state <= S_PUSH;
        S_PUSH:  state <= S_CLR;
        S_CLR:   state <= S_SUM;
        S_SUM:   if (sts.sum_done) state <= S_FIN;
        S_FIN:   state <= S_WAIT;
        S_WAIT:  if (sts.fin_done) begin state <= S_OUT; out_valid <= 1'b1; end
        S_OUT:   if (out_ready) begin state <= S_IDLE; out_valid <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/beat_interval_hrv_tracker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// beat_interval_hrv_tracker
// mean heart rate, mean amplitude and rmssd from a stream of beat times
// ---------------------------------------------------------------------------
// channel   dir  fields (lsb first)
// s_axis    in   tdata: beat_time_ms[31:0], pulse_amplitude[47:32]
// m_axis    out  tdata: mean_rate_bpm[7:0], rmssd_ms[19:8],
//                mean_amplitude[35:20], beat_accepted[36]
// cfg       in   cfg_we / cfg_index / cfg_data, 0 short, 1 long bound
//
// one transaction at a time; a stored beat runs the 24 step rate divide and
// the ring writes (a rejected or first beat skips both), then a short ring
// sweep, then the root search, one result bit at a time, that also carries
// the two mean divides
// rst is synchronous; rings hold no reset, fill counts guard their reads
// the result holds on m_axis until taken; s_axis_tready stays low until then
// ---------------------------------------------------------------------------
module beat_interval_hrv_tracker #(
  parameter int RATE_AVG_DEPTH      = bihrv_pkg::RATE_AVG_DEPTH_DEF,
  parameter int INTERVAL_DEPTH      = bihrv_pkg::INTERVAL_DEPTH_DEF,
  parameter int AMPLITUDE_AVG_DEPTH = bihrv_pkg::AMPLITUDE_AVG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // beat_time_ms, pulse_amplitude
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // mean_rate_bpm, rmssd_ms, mean_amplitude, beat_accepted
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import bihrv_pkg::*;

  bihrv_cmd_t cmd;
  bihrv_sts_t sts;
  logic [7:0]  rate;
  logic [11:0] rmssd;
  logic signed [15:0] amp;
  logic        acc;

  bihrv_ctrl u_ctrl (
    .clk, .rst,
    .in_fire   (s_axis_tvalid && s_axis_tready),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd, .sts
  );

  bihrv_datapath #(
    .RATE_AVG_DEPTH(RATE_AVG_DEPTH), .INTERVAL_DEPTH(INTERVAL_DEPTH),
    .AMPLITUDE_AVG_DEPTH(AMPLITUDE_AVG_DEPTH)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_time (s_axis_tdata[31:0]),
    .in_amp  ($signed(s_axis_tdata[47:32])),
    .cmd, .sts,
    .mean_rate_bpm (rate), .rmssd_ms (rmssd),
    .mean_amplitude(amp),  .beat_accepted(acc)
  );

  assign m_axis_tdata = {3'b000, acc, amp, rmssd, rate};
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for beat_interval_hrv_tracker: beat transactions are
// driven with random idling on both sides, a scoreboard predicts each result
// ---------------------------------------------------------------------------

class hrv_scoreboard;
  logic [11:0] short_ms, long_ms;
  logic [31:0] prev_time;
  bit          prev_ok;
  logic [15:0] rates [4];
  logic [15:0] amps [4];
  int          rate_fill, rate_slot;
  logic [11:0] ivs [30];
  int          iv_fill, iv_slot;
  longint unsigned sq_sum;
  logic [36:0] pending [$];
  int          errors;
  int          results_seen;
  int          accepted_seen;

  function new();
    short_ms = bihrv_pkg::SHORT_RESET;
    long_ms = bihrv_pkg::LONG_RESET;
    prev_ok = 0;
    prev_time = 0;
    rate_fill = 0; rate_slot = 0; iv_fill = 0; iv_slot = 0;
    sq_sum = 0;
    errors = 0;
    results_seen = 0;
    accepted_seen = 0;
  endfunction

  function void set_reg(bit idx, logic [11:0] v);
    if (idx == bihrv_pkg::REG_SHORT) short_ms = v;
    else long_ms = v;
  endfunction

  function longint unsigned sqd(logic [11:0] a, logic [11:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function logic [11:0] root_of_mean();
    longint unsigned d, four_s, t;
    logic [11:0] r, cand;
    if (iv_fill < 2) return 0;
    d = iv_fill - 1;
    four_s = sq_sum * 4;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      cand = r | (12'd1 << b);
      t = 2 * longint'(cand) - 1;
      if (t * t * d <= four_s) r = cand;
    end
    return r;
  endfunction

  // note one beat transaction once the block has taken it
  function void note_beat(logic [31:0] t, logic [15:0] amp);
    logic [31:0] iv;
    logic [31:0] rate;
    bit acc;
    int s, sum, n, mamp;
    longint unsigned rsum;
    logic [7:0] mrate;
    acc = 0;
    if (prev_ok) begin
      iv = t - prev_time;
      if (iv > short_ms && iv < long_ms && iv != 0) begin
        acc = 1;
        rate = (32'd15360000 + iv / 2) / iv;
        if (rate > 32'hFFFF) rate = 32'hFFFF;
        rates[rate_slot] = rate[15:0];
        amps[rate_slot] = amp;
        rate_slot = (rate_slot + 1) % 4;
        if (rate_fill < 4) rate_fill++;
        s = iv_slot;
        if (iv_fill >= 30) sq_sum -= sqd(ivs[(s + 1) % 30], ivs[s]);
        if (iv_fill >= 1) sq_sum += sqd(iv[11:0], ivs[(s + 29) % 30]);
        ivs[s] = iv[11:0];
        iv_slot = (s + 1) % 30;
        if (iv_fill < 30) iv_fill++;
      end
    end
    prev_time = t;
    prev_ok = 1;
    mrate = 0;
    mamp = 0;
    if (rate_fill > 0) begin
      rsum = 0;
      sum = 0;
      for (int i = 0; i < rate_fill; i++) begin
        rsum += rates[i];
        sum += $signed(amps[i]);
      end
      rsum = (rsum + rate_fill * 128) / (rate_fill * 256);
      mrate = (rsum > 255) ? 8'd255 : rsum[7:0];
      n = rate_fill;
      if (sum >= 0) mamp = (sum + n / 2) / n;
      else mamp = -((-sum + n / 2) / n);
    end
    pending.push_back({acc, mamp[15:0], root_of_mean(), mrate});
  endfunction

  task report(string what, logic [36:0] got, logic [36:0] want);
    errors++;
    if (errors <= 30) $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // compare one result transaction with the oldest prediction
  task check_result(logic [39:0] got);
    logic [36:0] exp_word;
    results_seen++;
    if (got[36]) accepted_seen++;
    if (pending.size() == 0) begin
      report("unexpected result", got[36:0], 0);
      return;
    end
    exp_word = pending.pop_front();
    if (got[7:0] !== exp_word[7:0]) report("mean_rate_bpm", got[36:0], exp_word);
    if (got[19:8] !== exp_word[19:8]) report("rmssd_ms", got[36:0], exp_word);
    if (got[35:20] !== exp_word[35:20]) report("mean_amplitude", got[36:0], exp_word);
    if (got[36] !== exp_word[36]) report("beat_accepted", got[36:0], exp_word);
  endtask
endclass

module tb;
  import bihrv_pkg::*;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_we, cfg_index;
  logic [11:0] cfg_data;

  hrv_scoreboard sb;
  int  send_idle, recv_stall;   // percent chance of a gap per cycle
  int  cycles;
  logic [31:0] now_ms;          // running beat clock

  beat_interval_hrv_tracker dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit: ~1300 beats with heavy stalls, taken many times over
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("timeout");
        $display("[beat_interval_hrv_tracker] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, results checked at the rising edge
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      @(negedge clk);
      m_axis_tready = ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(bit idx, logic [11:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, v);
  endtask

  // one beat transaction, with optional sender idling first
  task automatic send_beat(logic [31:0] t, logic [15:0] amp);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tdata = {amp, t};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(t, amp);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  // wait for all results, plus room for the block to settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic beat_after(int gap);
    now_ms = now_ms + gap;
    send_beat(now_ms, 16'($urandom));
  endtask

  initial begin
    logic [11:0] lo, hi;
    int mode;
    sb = new();
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    send_idle = 0; recv_stall = 0;
    now_ms = 32'hFFFF_F000;
    repeat (3) @(negedge clk);
    rst = 0;

    // directed: first beat, rejects on both sides, wrap of the time stamp,
    // amplitude extremes, rmssd below two intervals
    send_beat(now_ms, 16'h8000);
    beat_after(300);
    beat_after(1500);
    beat_after(1499);
    send_beat(now_ms + 301, 16'h7FFF); now_ms += 301;
    beat_after(4000);
    for (int i = 0; i < 6; i++) begin
      now_ms += (i % 2) ? 400 : 1400;
      send_beat(now_ms, (i % 2) ? 16'h8000 : 16'h8001);
    end
    drain();
    // fast rate saturation, mean rate above 255
    write_reg(REG_SHORT, 12'd0);
    write_reg(REG_LONG, 12'd4095);
    for (int i = 0; i < 5; i++) beat_after(1);
    beat_after(4094);
    beat_after(2);
    beat_after(4094);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      // new bounds each phase, with extremes in some
      lo = $urandom_range(1, 600);
      hi = $urandom_range(900, 4095);
      if (phase == 3) begin lo = 12'd1; hi = 12'd4095; end
      if (phase == 6) begin lo = 12'hFFF; hi = 12'd1; end
      write_reg(REG_SHORT, lo);
      write_reg(REG_LONG, hi);
      for (int i = 0; i < 160; i++) begin
        mode = $urandom_range(99);
        if (mode < 75) beat_after($urandom_range(250, 1600));
        else if (mode < 85) beat_after($urandom_range(1, 4095));
        else if (mode < 95) beat_after($urandom_range(1, 40) * 100);
        else send_beat($urandom, 16'($urandom));
        if (i == 80) drain();
      end
      drain();
    end

    $display("%0d results checked, %0d beats stored, bounds swept over 10 settings",
             sb.results_seen, sb.accepted_seen);
    $display("idling phases: none, sender, receiver and both");
    if (sb.errors == 0) $display("[beat_interval_hrv_tracker] OK");
    else $display("[beat_interval_hrv_tracker] ERROR");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/bihrv_pkg.sv
hw/rtl/bihrv_datapath.sv
hw/rtl/bihrv_ctrl.sv
hw/rtl/beat_interval_hrv_tracker.sv
bench/tb.sv
